FILE: rtl/core/sfrx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrx_pkg
// Shared types and constants for the sync frame receiver with XOR check.
// ----------------------------------------------------------------------------
package sfrx_pkg;

    localparam int BYTE_W            = 8;
    localparam int PAYLOAD_FIELDS    = 3;   // mode, command, status on the result
    localparam int PAYLOAD_BYTES_DEF = 3;
    localparam int CFG_INDEX_W       = 2;

    // Register reset values
    localparam logic [BYTE_W-1:0] FIRST_SYNC_RST     = 8'h55;
    localparam logic [BYTE_W-1:0] SECOND_SYNC_RST    = 8'hAA;
    localparam logic [BYTE_W-1:0] TIMEOUT_RELOAD_RST = 8'd10;

    // Beat kind carried on s_tuser
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_SYNC     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_SYNC    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_RELOAD = 2'd2;

    typedef enum logic [1:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_DATA,
        PH_CHECK
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] first_sync;
        logic [BYTE_W-1:0] second_sync;
        logic [BYTE_W-1:0] timeout_reload;
    } cfg_t;

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] data_byte;
    } beat_t;

    typedef struct packed {
        logic              frame_ok;
        logic [BYTE_W-1:0] frame_mode;
        logic [BYTE_W-1:0] frame_command;
        logic [BYTE_W-1:0] frame_status;
    } result_t;

endpackage

FILE: rtl/core/sfrx_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrx_cfg_regs
// Sync byte values and inter-byte timeout reload, written over the config
// channel. Writes to an unused index are accepted and dropped.
// ----------------------------------------------------------------------------
module sfrx_cfg_regs
    import sfrx_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]      cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the write beat
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FIRST_SYNC:     cfg_next.first_sync     = cfg_data;
                CFG_SECOND_SYNC:    cfg_next.second_sync    = cfg_data;
                CFG_TIMEOUT_RELOAD: cfg_next.timeout_reload = cfg_data;
                default:            cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_sync     <= FIRST_SYNC_RST;
            cfg_reg.second_sync    <= SECOND_SYNC_RST;
            cfg_reg.timeout_reload <= TIMEOUT_RELOAD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/core/sfrx_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrx_in_stage
// Input register: captures one beat per cycle and hands it to the frame
// engine when the result side can take it.
// ----------------------------------------------------------------------------
module sfrx_in_stage
    import sfrx_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  beat_t s_beat,
    input  logic  advance,
    output logic  beat_valid,
    output beat_t beat
);

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;

    // Free when empty or when the held beat moves on this cycle
    assign s_ready    = !valid_reg || advance;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload holds while stalled
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            beat_reg <= s_beat;
        end
    end

endmodule

FILE: rtl/core/sfrx_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrx_engine
// Frame state machine: sync hunt, payload capture with running XOR, check
// byte compare and inter-byte timeout. Consumes one beat per cycle while take is high.
// ----------------------------------------------------------------------------
module sfrx_engine
    import sfrx_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    take,
    input  beat_t   beat,
    output logic    res_valid,
    output result_t res
);

    localparam int IDX_W = $clog2(PAYLOAD_BYTES + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PAYLOAD_BYTES);

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [BYTE_W-1:0] timeout_reg, timeout_next;
    logic [BYTE_W-1:0] store_reg [PAYLOAD_BYTES];

    logic              byte_beat;
    logic              restart;
    phase_t            cur_phase;
    logic [BYTE_W-1:0] cur_xor;
    logic [IDX_W-1:0]  cur_idx;
    logic              store_we;
    logic [BYTE_W-1:0] pay [PAYLOAD_FIELDS];

    assign byte_beat = take && (beat.op == OP_BYTE);

    // Expired timeout restarts the hunt before the byte is examined
    assign restart   = (timeout_reg == '0);
    assign cur_phase = restart ? PH_SYNC1 : phase_reg;
    assign cur_xor   = restart ? '0 : xor_reg;
    assign cur_idx   = restart ? '0 : idx_reg;
    assign store_we  = byte_beat && (cur_phase == PH_DATA);

    // Next state
    always_comb begin
        phase_next   = phase_reg;
        xor_next     = xor_reg;
        idx_next     = idx_reg;
        timeout_next = timeout_reg;
        if (take && (beat.op == OP_TICK)) begin
            if (timeout_reg != '0) begin
                timeout_next = timeout_reg - 1'b1;
            end
        end else if (byte_beat) begin
            phase_next = cur_phase;
            xor_next   = cur_xor;
            idx_next   = cur_idx;
            unique case (cur_phase)
                PH_SYNC1: begin
                    if (beat.data_byte == cfg.first_sync) begin
                        phase_next   = PH_SYNC2;
                        timeout_next = cfg.timeout_reload;
                    end else begin
                        timeout_next = '0;
                    end
                end
                PH_SYNC2: begin
                    if (beat.data_byte == cfg.second_sync) begin
                        phase_next   = PH_DATA;
                        timeout_next = cfg.timeout_reload;
                    end else begin
                        timeout_next = '0;
                    end
                end
                PH_DATA: begin
                    xor_next     = cur_xor ^ beat.data_byte;
                    idx_next     = cur_idx + 1'b1;
                    timeout_next = cfg.timeout_reload;
                    if (idx_next == IDX_LAST) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    // Frame ends: next byte restarts the hunt
                    timeout_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SYNC1;
            xor_reg     <= '0;
            idx_reg     <= '0;
            timeout_reg <= '0;
        end else begin
            phase_reg   <= phase_next;
            xor_reg     <= xor_next;
            idx_reg     <= idx_next;
            timeout_reg <= timeout_next;
        end
    end

    // Payload store, one register per byte position; unused result fields
    // read as zero
    for (genvar k = 0; k < PAYLOAD_FIELDS; k++) begin : g_pay
        if (k < PAYLOAD_BYTES) begin : g_used
            always_ff @(posedge aclk) begin
                if (store_we && (cur_idx == IDX_W'(k))) begin
                    store_reg[k] <= beat.data_byte;
                end
            end
            assign pay[k] = store_reg[k];
        end else begin : g_unused
            assign pay[k] = '0;
        end
    end

    // Result on the check byte
    always_comb begin
        res_valid         = byte_beat && (cur_phase == PH_CHECK);
        res.frame_ok      = (cur_xor == beat.data_byte);
        res.frame_mode    = pay[0];
        res.frame_command = pay[1];
        res.frame_status  = pay[2];
    end

endmodule

FILE: rtl/core/sfrx_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrx_out_stage
// Result register with a skid entry, so the engine can still deliver one more
// result after the output stalls and the upstream ready is a register.
// ----------------------------------------------------------------------------
module sfrx_out_stage
    import sfrx_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    up_valid,
    output logic    up_ready,
    input  result_t up_res,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg;
    result_t skid_reg;
    logic    main_load;

    assign up_ready  = !skid_valid_reg;
    assign m_valid   = main_valid_reg;
    assign m_res     = main_reg;
    assign main_load = !main_valid_reg || m_ready;

    // Refill main from skid first, else from upstream; park in skid on stall
    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (main_load) begin
            main_valid_next = skid_valid_reg || up_valid;
            skid_valid_next = 1'b0;
        end else if (up_valid && up_ready) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (main_load) begin
            main_reg <= skid_valid_reg ? skid_reg : up_res;
        end
        if (!main_load && up_valid && up_ready) begin
            skid_reg <= up_res;
        end
    end

endmodule

FILE: rtl/core/sync_frame_receiver_xor_check_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_frame_receiver_xor_check_core
// Frame receiver that hunts two sync bytes, captures the payload and checks
// it against an XOR block check byte.
// ----------------------------------------------------------------------------
// Input beats are received bytes (s_tuser = 0) or timer ticks (s_tuser = 1).
// The block takes one beat every cycle while the output skid entry is free; a
// beat passes an input register, the combinational frame logic and a result
// register, and its frame result is valid on the master side once the result
// register holds it, where it waits for m_tready. A two-entry output stage
// (result register plus skid) keeps beats flowing while a result waits.
// Ticks count the inter-byte timeout down; a byte arriving with the timeout
// at zero restarts the sync hunt. Each check byte yields one result with
// m_tuser = 1 on a match and 0 on a mismatch. Configuration writes are taken
// at any time but must be issued only while the block is idle.
// ----------------------------------------------------------------------------
module sync_frame_receiver_xor_check_core
    import sfrx_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] data_byte
    input  logic                   s_tuser,   // [0] op

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,   // [7:0] frame_mode, [15:8] frame_command,
                                              // [23:16] frame_status
    output logic                   m_tuser,   // [0] frame_ok

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]      cfg_data
);

    cfg_t    cfg;
    beat_t   s_beat;
    beat_t   beat;
    logic    beat_valid;
    logic    out_ready;
    logic    take;
    logic    res_valid;
    result_t res;
    result_t m_res;

    assign s_beat.op        = s_tuser;
    assign s_beat.data_byte = s_tdata;
    assign take             = beat_valid && out_ready;

    sfrx_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfrx_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_beat     (s_beat),
        .advance    (out_ready),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    sfrx_engine #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .take      (take),
        .beat      (beat),
        .res_valid (res_valid),
        .res       (res)
    );

    sfrx_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (res_valid),
        .up_ready (out_ready),
        .up_res   (res),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (m_res)
    );

    // Pack the result beat
    assign m_tuser = m_res.frame_ok;
    assign m_tdata = {m_res.frame_status, m_res.frame_command, m_res.frame_mode};

endmodule

FILE: bench/sfrx_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrx_frame_checker
// Watches the beat, result and register channels of the sync frame receiver,
// keeps a cycle-free model of the deframer and compares every result beat
// with the frame the model expects.
// ----------------------------------------------------------------------------
module sfrx_frame_checker
    import sfrx_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] data_byte
    input  logic                   s_tuser,   // [0] op

    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [23:0]            m_tdata,   // [7:0] frame_mode, [15:8] frame_command,
                                              // [23:16] frame_status
    input  logic                   m_tuser,   // [0] frame_ok

    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]      cfg_data,

    output int                     fail_count,
    output int                     frames_pending
);

    // Frames predicted but not yet seen on the master side
    result_t           awaited_frames[$];

    // Model of the deframer state and its registers
    cfg_t              regs;
    phase_t            hunt_phase;
    logic [BYTE_W-1:0] bcc;
    logic [BYTE_W-1:0] payload [PAYLOAD_FIELDS];
    logic [1:0]        slot;
    logic [BYTE_W-1:0] gap_timer;

    // Report one field; return 1 when it differs
    function automatic int field_differs(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin : track
        result_t want;
        if (!aresetn) begin
            // Reset model and drop anything pending
            fail_count          = 0;
            regs.first_sync     = FIRST_SYNC_RST;
            regs.second_sync    = SECOND_SYNC_RST;
            regs.timeout_reload = TIMEOUT_RELOAD_RST;
            hunt_phase          = PH_SYNC1;
            bcc                 = '0;
            slot                = '0;
            gap_timer           = '0;
            for (int k = 0; k < PAYLOAD_FIELDS; k++) payload[k] = '0;
            awaited_frames.delete();
        end else begin
            // Compare a result beat with the oldest predicted frame
            if (m_tvalid && m_tready) begin
                if (awaited_frames.size() == 0) begin
                    fail_count++;
                    $display("%0t ns: unexpected result beat, expected none, actual ok=%0b data=%h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want = awaited_frames.pop_front();
                    fail_count += field_differs("frame_ok", {7'b0, want.frame_ok},
                                                {7'b0, m_tuser});
                    fail_count += field_differs("frame_mode", want.frame_mode, m_tdata[7:0]);
                    fail_count += field_differs("frame_command", want.frame_command,
                                                m_tdata[15:8]);
                    fail_count += field_differs("frame_status", want.frame_status,
                                                m_tdata[23:16]);
                end
            end

            // Track register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FIRST_SYNC:     regs.first_sync     = cfg_data;
                    CFG_SECOND_SYNC:    regs.second_sync    = cfg_data;
                    CFG_TIMEOUT_RELOAD: regs.timeout_reload = cfg_data;
                    default: ;
                endcase
            end

            // Advance the deframer on each accepted beat
            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_TICK) begin
                    if (gap_timer != 0) gap_timer = gap_timer - 8'd1;
                end else begin
                    // Expired gap: restart the hunt before looking at the byte
                    if (gap_timer == 0) begin
                        hunt_phase = PH_SYNC1;
                        bcc        = '0;
                        slot       = '0;
                    end
                    case (hunt_phase)
                        PH_SYNC1: begin
                            if (s_tdata == regs.first_sync) begin
                                hunt_phase = PH_SYNC2;
                                gap_timer  = regs.timeout_reload;
                            end else begin
                                gap_timer = '0;
                            end
                        end
                        PH_SYNC2: begin
                            if (s_tdata == regs.second_sync) begin
                                hunt_phase = PH_DATA;
                                gap_timer  = regs.timeout_reload;
                            end else begin
                                gap_timer = '0;
                            end
                        end
                        PH_DATA: begin
                            payload[slot % 3] = s_tdata;
                            bcc  = bcc ^ s_tdata;
                            slot = slot + 2'd1;
                            if (slot >= PAYLOAD_BYTES) hunt_phase = PH_CHECK;
                            gap_timer = regs.timeout_reload;
                        end
                        PH_CHECK: begin
                            // Fields past the payload length read as zero
                            want.frame_ok      = (bcc == s_tdata);
                            want.frame_mode    = (PAYLOAD_BYTES > 0) ? payload[0] : '0;
                            want.frame_command = (PAYLOAD_BYTES > 1) ? payload[1] : '0;
                            want.frame_status  = (PAYLOAD_BYTES > 2) ? payload[2] : '0;
                            awaited_frames.push_back(want);
                            gap_timer = '0;
                        end
                        default: begin
                            hunt_phase = PH_SYNC1;
                            bcc        = '0;
                            slot       = '0;
                            gap_timer  = '0;
                        end
                    endcase
                end
            end
        end
        frames_pending = awaited_frames.size();
    end

endmodule

FILE: bench/tb_sync_frame_receiver_xor_check_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_frame_receiver_xor_check_core
// Drives byte and tick beats into the sync frame receiver under several sync
// and timeout settings: a directed opening, then mostly well-formed frames
// with random payload, ticks and timeouts, mixed with noise and broken frames.
// Both sides idle at random; the receiver holds off once for a long stretch.
// The frame checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_sync_frame_receiver_xor_check_core;
    import sfrx_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 9;
    localparam int IDLE_PCT     = 31;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 400000;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;   // [7:0] data_byte
    logic                   s_tuser   = 1'b0; // [0] op
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [23:0]            m_tdata;          // [7:0] mode, [15:8] command, [23:16] status
    logic                   m_tuser;          // [0] frame_ok
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]      cfg_data  = '0;

    int                     fail_count;
    int                     frames_pending;
    int                     cycle_count  = 0;
    int                     hold_trigger = 0;
    logic                   calm         = 1'b0;

    // Current register values, used to build well-formed frames
    logic [7:0]             cur_first  = FIRST_SYNC_RST;
    logic [7:0]             cur_second = SECOND_SYNC_RST;
    logic [7:0]             cur_reload = TIMEOUT_RELOAD_RST;

    sync_frame_receiver_xor_check_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sfrx_frame_checker #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES_DEF)
    ) frame_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .frames_pending (frames_pending)
    );

    // Clock
    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Cycle count and watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_sync_frame_receiver_xor_check_core failed");
        $finish;
    end

    // Receiver side: random stalls, calm stretches and one long hold-off
    initial begin : rx_side
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_seen != hold_trigger) begin
                hold_seen = hold_trigger;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (calm) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        logic [31:0] w;
        w = $urandom;
        return w[7:0];
    endfunction

    // Offer one beat, with a random idle gap ahead of it, and wait for it to go
    task automatic send_beat(input logic op, input logic [7:0] b);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < IDLE_PCT);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering and wait until every predicted frame is out and the block is quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (frames_pending != 0);
        @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [7:0] first, input logic [7:0] second,
                                 input logic [7:0] reload);
        settle();
        write_reg(CFG_FIRST_SYNC, first);
        write_reg(CFG_SECOND_SYNC, second);
        write_reg(CFG_TIMEOUT_RELOAD, reload);
        cur_first  = first;
        cur_second = second;
        cur_reload = reload;
    endtask

    // Mostly well-formed frames with random payload and ticks; some noise and breakage
    task automatic frame_traffic(input int beats);
        logic [7:0]  body [6];
        logic [31:0] w;
        int          sent;
        int          n_bytes;
        int          n_ticks;
        int          r;
        sent = 0;
        while (sent < beats) begin
            if ($urandom_range(99) < 15) begin
                // Noise: a lone random byte or tick
                w = $urandom;
                send_beat(w[8], w[7:0]);
                sent++;
            end else begin
                body[0] = cur_first;
                body[1] = cur_second;
                body[2] = rand_byte();
                body[3] = rand_byte();
                body[4] = rand_byte();
                body[5] = ($urandom_range(99) < 70) ? (body[2] ^ body[3] ^ body[4])
                                                    : rand_byte();
                // Break one of the sync bytes now and then
                if ($urandom_range(99) < 8) begin
                    r       = $urandom_range(1);
                    body[r] = rand_byte();
                end
                // Cut the frame short now and then
                n_bytes = ($urandom_range(99) < 85) ? 6 : $urandom_range(5, 1);
                for (int k = 0; k < n_bytes; k++) begin
                    if (k > 0) begin
                        r = $urandom_range(99);
                        if (r < 75) begin
                            n_ticks = 0;
                        end else if (r < 95) begin
                            n_ticks = $urandom_range(3, 1);
                        end else begin
                            // Land just short of, on, or just past the timeout
                            n_ticks = int'(cur_reload) - 1 + $urandom_range(2);
                            if (n_ticks < 0) n_ticks = 0;
                        end
                        for (int j = 0; j < n_ticks; j++) send_beat(OP_TICK, rand_byte());
                        sent += n_ticks;
                    end
                    send_beat(OP_BYTE, body[k]);
                    sent++;
                end
            end
        end
    endtask

    // Stimulus and verdict
    initial begin : stimulus
        logic [7:0] f;
        logic [7:0] s;
        logic [7:0] r;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Timeout is zero after reset: first byte restarts the hunt, then syncs
        send_beat(OP_BYTE, 8'h55);
        send_beat(OP_BYTE, 8'hAA);
        // Extreme payload, matching check byte
        send_beat(OP_BYTE, 8'h00);
        send_beat(OP_BYTE, 8'hFF);
        send_beat(OP_BYTE, 8'h5A);
        send_beat(OP_BYTE, 8'hA5);
        // Tick with the timeout already cleared by the check byte
        send_beat(OP_TICK, 8'hFF);
        // Frame with a tick inside and a bad check byte
        send_beat(OP_BYTE, 8'h55);
        send_beat(OP_BYTE, 8'hAA);
        send_beat(OP_BYTE, 8'h12);
        send_beat(OP_TICK, 8'h00);
        send_beat(OP_BYTE, 8'h34);
        send_beat(OP_BYTE, 8'h56);
        send_beat(OP_BYTE, 8'h00);
        // Wrong first sync, then wrong second sync followed by a restart
        send_beat(OP_BYTE, 8'h13);
        send_beat(OP_BYTE, 8'h55);
        send_beat(OP_BYTE, 8'h3C);
        send_beat(OP_BYTE, 8'hAA);
        frame_traffic(280);

        // Reload of one: one tick between bytes expires the gap
        apply_setting(8'h00, 8'hFF, 8'd1);
        send_beat(OP_BYTE, 8'h00);
        send_beat(OP_TICK, 8'h5A);
        send_beat(OP_BYTE, 8'hFF);
        send_beat(OP_BYTE, 8'h00);
        send_beat(OP_BYTE, 8'hFF);
        send_beat(OP_BYTE, 8'h80);
        send_beat(OP_BYTE, 8'h01);
        send_beat(OP_BYTE, 8'h7F);
        send_beat(OP_BYTE, 8'hFE);
        calm = 1'b1;
        frame_traffic(150);
        calm = 1'b0;
        frame_traffic(150);

        // Highest reload
        apply_setting(8'hFF, 8'h00, 8'd255);
        frame_traffic(320);

        // Random syncs, short reload, receiver holds off while beats keep coming
        f = rand_byte();
        s = rand_byte();
        r = 8'd2 + 8'($urandom_range(14));
        apply_setting(f, s, r);
        hold_trigger++;
        frame_traffic(320);

        // Equal sync bytes and a zero reload: every byte after a match restarts
        apply_setting(8'h3C, 8'h3C, 8'd0);
        send_beat(OP_BYTE, 8'h3C);
        send_beat(OP_BYTE, 8'h3C);
        send_beat(OP_TICK, 8'h3C);
        send_beat(OP_BYTE, 8'h3C);
        frame_traffic(80);

        // Random syncs and reload
        f = rand_byte();
        s = rand_byte();
        r = 8'd1 + 8'($urandom_range(254));
        apply_setting(f, s, r);
        frame_traffic(300);

        settle();
        if (fail_count == 0 && frames_pending == 0) begin
            $display("tb_sync_frame_receiver_xor_check_core passed");
        end else begin
            $display("tb_sync_frame_receiver_xor_check_core failed");
        end
        $finish;
    end

endmodule
